>>> hw/rtl/twa_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed window average package
// Shared sample type, constants and the sequencer state type.
// ----------------------------------------------------------------------------
package twa_pkg;

    // Width of one temperature sample and of the averaged result.
    localparam int SAMPLE_W = 8;

    // Largest sample value; the running minimum starts here.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hFF;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_TAIL,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/twa_if.sv
// ----------------------------------------------------------------------------
// Trimmed window average channels
// Valid/ready channels for the sample input and the result output.
// ----------------------------------------------------------------------------

// Sample input channel.
interface twa_in_if;
    logic             valid;
    logic             ready;
    twa_pkg::t_sample sample;
    logic             read_failed;

    modport source (output valid, output sample, output read_failed, input ready);
    modport sink   (input valid, input sample, input read_failed, output ready);
endinterface

// Result output channel.
interface twa_out_if;
    logic             valid;
    logic             ready;
    twa_pkg::t_sample temperature;
    logic             error;
    logic             filtered;

    modport source (output valid, output temperature, output error, output filtered,
                    input ready);
    modport sink   (input valid, input temperature, input error, input filtered,
                    output ready);
endinterface

>>> hw/rtl/twa_window_mem.sv
// ----------------------------------------------------------------------------
// Window sample memory
// One write port and one read port with registered read data. Entries that
// were never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module twa_window_mem #(
    parameter int DEPTH  = 10,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  twa_pkg::t_sample  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output twa_pkg::t_sample  o_rdata
);

    twa_pkg::t_sample r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    twa_pkg::t_sample r_rdata;

    // Storage array write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits, cleared together at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Registered read; an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/twa_divider.sv
// ----------------------------------------------------------------------------
// Constant divider
// Division by a fixed divisor through a multiplication by its scaled
// reciprocal. The quotient is registered on the start pulse.
// The dividend must be below 2^NUM_W and the quotient must fit a sample.
// ----------------------------------------------------------------------------
module twa_divider #(
    parameter int NUM_W   = 12,
    parameter int DIVISOR = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    output logic             o_done,
    output twa_pkg::t_sample o_quotient
);

    // The shift covers the dividend width plus the ceiling of log2 of the divisor, so the
    // rounded-up reciprocal gives the exact truncated quotient for every dividend.
    localparam int SHIFT   = NUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = NUM_W + 1;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PROD_W-1:0] prod;
    logic              r_done;
    twa_pkg::t_sample  r_quot;

    // Scaled product; the quotient sits right above the shift.
    assign prod = PROD_W'(i_dividend) * PROD_W'(RECIP);

    // Done flag is the registered start pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Quotient register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= prod[SHIFT +: twa_pkg::SAMPLE_W];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

>>> hw/rtl/trimmed_window_average.sv
// Sequence: a failed read goes from the idle state through the done state to the output
// register, a warm-up sample also passes the update state, and a filtered sample scans
// every window entry through the single memory read port, then divides and is done.
// One item is in work at a time; the next transfer is taken once the result is in the
// output register, so a held output stalls the input. Synchronous active-low reset
// clears the window, sum, slot and count.
// ----------------------------------------------------------------------------
// Trimmed window average
// Ring window of temperature samples in a memory, with a running sum; after
// warm-up it answers with the window mean without its minimum and maximum.
// ----------------------------------------------------------------------------
module trimmed_window_average #(
    parameter int WINDOW = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twa_in_if.sink     i_in,
    twa_out_if.source  o_out
);

    localparam int AW    = $clog2(WINDOW);
    localparam int SUM_W = twa_pkg::SAMPLE_W + $clog2(WINDOW);

    twa_pkg::t_state  r_state, n_state;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [AW-1:0]    r_slot, n_slot;
    logic [AW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_fold, n_fold;
    twa_pkg::t_sample r_sample, n_sample;
    twa_pkg::t_sample r_lo, n_lo;
    twa_pkg::t_sample r_hi, n_hi;
    twa_pkg::t_sample r_res_temp, n_res_temp;
    logic             r_res_err, n_res_err;
    logic             r_res_filt, n_res_filt;
    logic             r_out_valid, n_out_valid;
    twa_pkg::t_sample r_out_temp, n_out_temp;
    logic             r_out_err, n_out_err;
    logic             r_out_filt, n_out_filt;

    logic             mem_we;
    logic [AW-1:0]    mem_raddr;
    twa_pkg::t_sample mem_rdata;
    logic             div_start;
    logic             div_done;
    twa_pkg::t_sample div_quot;
    logic [SUM_W-1:0] div_dividend;

    // Window storage.
    twa_window_mem #(
        .DEPTH  (WINDOW),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Division of the trimmed sum by WINDOW - 2.
    assign div_dividend = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);

    twa_divider #(
        .NUM_W   (SUM_W),
        .DIVISOR (WINDOW - 2)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign i_in.ready = (r_state == twa_pkg::S_IDLE);

    // Sequencer: next state, datapath updates and memory control.
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_fold      = 1'b0;
        n_sample    = r_sample;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res_temp  = r_res_temp;
        n_res_err   = r_res_err;
        n_res_filt  = r_res_filt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_temp  = r_out_temp;
        n_out_err   = r_out_err;
        n_out_filt  = r_out_filt;
        mem_we      = 1'b0;
        mem_raddr   = r_slot;
        div_start   = 1'b0;

        // Fold the entry read in the previous cycle into the running extremes.
        if (r_fold) begin
            if (mem_rdata < r_lo) begin
                n_lo = mem_rdata;
            end
            if (mem_rdata > r_hi) begin
                n_hi = mem_rdata;
            end
        end

        case (r_state)
            twa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_sample = i_in.sample;
                    if (i_in.read_failed) begin
                        n_res_temp = '0;
                        n_res_err  = 1'b1;
                        n_res_filt = 1'b0;
                        n_state    = twa_pkg::S_DONE;
                    end else begin
                        // The oldest entry is read here and arrives next cycle.
                        n_state = twa_pkg::S_UPDATE;
                    end
                end
            end
            twa_pkg::S_UPDATE: begin
                mem_we = 1'b1;
                n_sum  = r_sum - SUM_W'(mem_rdata) + SUM_W'(r_sample);
                n_slot = (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (r_fill != AW'(WINDOW - 1)) begin
                    n_fill     = r_fill + 1'b1;
                    n_res_temp = r_sample;
                    n_res_err  = 1'b0;
                    n_res_filt = 1'b0;
                    n_state    = twa_pkg::S_DONE;
                end else begin
                    n_idx   = '0;
                    n_lo    = twa_pkg::SAMPLE_MAX;
                    n_hi    = '0;
                    n_state = twa_pkg::S_SCAN;
                end
            end
            twa_pkg::S_SCAN: begin
                // Walk all window entries, one read per cycle.
                mem_raddr = r_idx;
                n_fold    = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == AW'(WINDOW - 1)) begin
                    n_state = twa_pkg::S_TAIL;
                end
            end
            twa_pkg::S_TAIL: begin
                n_state = twa_pkg::S_DIV_START;
            end
            twa_pkg::S_DIV_START: begin
                div_start = 1'b1;
                n_state   = twa_pkg::S_DIV_WAIT;
            end
            twa_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_res_temp = div_quot;
                    n_res_err  = 1'b0;
                    n_res_filt = 1'b1;
                    n_state    = twa_pkg::S_DONE;
                end
            end
            twa_pkg::S_DONE: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_res_temp;
                    n_out_err   = r_res_err;
                    n_out_filt  = r_res_filt;
                    n_state     = twa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = twa_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twa_pkg::S_IDLE;
            r_sum       <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_fold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_fold      <= n_fold;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_sample   <= n_sample;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_res_temp <= n_res_temp;
        r_res_err  <= n_res_err;
        r_res_filt <= n_res_filt;
        r_out_temp <= n_out_temp;
        r_out_err  <= n_out_err;
        r_out_filt <= n_out_filt;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.temperature = r_out_temp;
    assign o_out.error       = r_out_err;
    assign o_out.filtered    = r_out_filt;

    // The warm-up count saturates one short of the window.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= AW'(WINDOW - 1))
        else $error("warm-up count beyond window");

    // An error result carries a zero temperature and is never filtered.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> (!o_out.filtered && o_out.temperature == '0))
        else $error("malformed error result");

    // Every good sample moves the write slot on.
    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twa_pkg::S_UPDATE) |=> (r_slot != $past(r_slot)))
        else $error("write slot did not advance");

    // A pending result waits while the output register is still held.
    a_result_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twa_pkg::S_DONE && r_out_valid && !o_out.ready)
        |=> (r_state == twa_pkg::S_DONE))
        else $error("result overwrote a held output");

endmodule
